FILE: design/mat_pkg.sv
// Shared types and constants for the multi-turn angle tracker.
// No dependencies; every other design file imports this package.
`default_nettype none

package mat_pkg;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int DPC_W   = 25;
    localparam int ANGLE_W = 48;
    localparam int TURN_W  = 25;   // single-turn angle, Q16.16 below 360 degrees
    localparam int TC_W    = 14;   // signed turn count
    localparam int PROD_W  = RAW_W + DPC_W;

    // One turn is 360 * 2^16 = 45 * 2^19, so a modulo splits into low bits and a mod-45
    localparam int FRAC_SH = 19;
    localparam int TURN_DIV = 45;
    localparam logic [TURN_W-1:0] TURN_Q      = 25'd23592960;
    localparam logic [TURN_W-1:0] HALF_TURN_Q = 25'd11796480;

    // Reciprocal of 45 for the scaler: exact for quotients below 2^22
    localparam int SC_Q_W   = PROD_W - FRAC_SH;
    localparam int SC_REC_W = 23;
    localparam int SC_REC_SH = 28;
    localparam logic [SC_REC_W-1:0] SC_REC = 23'd5965233;

    // Reciprocal of 45 for the wrap stage: exact for values below 2^30
    localparam int WR_H_W    = ANGLE_W - FRAC_SH;      // 29-bit signed turn part
    localparam int WR_U_W    = WR_H_W + 1;
    localparam int WR_REC_W  = 31;
    localparam int WR_REC_SH = 36;
    localparam logic [WR_REC_W-1:0] WR_REC = 31'd1527099484;
    // Multiple of 45 just above 2^28 that lifts the signed turn part to non-negative
    localparam logic [WR_U_W-1:0] WR_BIAS = 30'd268435485;

    localparam logic [DPC_W-1:0] DPC_RESET = 25'd2880;
    localparam int TURN_FOLD_LIMIT_DEF = 5000;

    // Request codes
    localparam logic REQ_SAMPLE   = 1'b0;
    localparam logic REQ_RELOCATE = 1'b1;

    typedef struct packed {
        logic                      req;
        logic signed [ANGLE_W-1:0] target;
        logic [TURN_W-1:0]         cur;
    } t_sample;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] total;
        logic                      init;
    } t_result;

    // Remainder of a value below 2^30 by 45, given its quotient
    function automatic logic [5:0] rem45(input logic [WR_U_W-1:0] v,
                                         input logic [WR_U_W-1:0] q);
        logic [WR_U_W-1:0] p;
        p = (q << 5) + (q << 3) + (q << 2) + q;
        return 6'(v - p);
    endfunction

endpackage

`default_nettype wire

FILE: design/mat_scale.sv
// Scaler for the multi-turn angle tracker: raw count times degrees-per-count,
// reduced modulo one turn over two register stages. Depends on mat_pkg.
`default_nettype none

module mat_scale (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic [mat_pkg::DPC_W-1:0]        i_dpc,
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic                             i_req,
    input  wire logic [mat_pkg::RAW_W-1:0]        i_raw,
    input  wire logic signed [mat_pkg::ANGLE_W-1:0] i_target,
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output mat_pkg::t_sample                      o_data
);
    import mat_pkg::*;

    logic                       r_s1_valid;
    logic                       r_s1_req;
    logic signed [ANGLE_W-1:0]  r_s1_target;
    logic [PROD_W-1:0]          r_s1_prod;
    logic                       s1_ready;
    logic                       s2_ready;

    logic [SC_Q_W-1:0]          q_hi;
    logic [SC_Q_W+SC_REC_W-1:0] q_mul;
    logic [WR_U_W-1:0]          q_div;
    logic [5:0]                 q_rem;
    logic [PROD_W-1:0]          n_prod;

    assign s2_ready = !o_valid || i_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign n_prod = PROD_W'(i_raw) * PROD_W'(i_dpc);

    // Split off the whole multiples of 2^19 and take them modulo 45
    assign q_hi  = r_s1_prod[PROD_W-1:FRAC_SH];
    assign q_mul = (SC_Q_W+SC_REC_W)'(q_hi) * (SC_Q_W+SC_REC_W)'(SC_REC);
    assign q_div = WR_U_W'(q_mul >> SC_REC_SH);
    assign q_rem = rem45(WR_U_W'(q_hi), q_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_valid;
        end
        if (s1_ready && i_valid) begin
            r_s1_req    <= i_req;
            r_s1_target <= i_target;
            r_s1_prod   <= n_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (s2_ready) begin
            o_valid <= r_s1_valid;
        end
        if (s2_ready && r_s1_valid) begin
            o_data.req    <= r_s1_req;
            o_data.target <= r_s1_target;
            o_data.cur    <= {q_rem, r_s1_prod[FRAC_SH-1:0]};
        end
    end

endmodule

`default_nettype wire

FILE: design/mat_core.sv
// Tracking core of the multi-turn angle tracker: turn counting, folding,
// relocation and the saturated total, all in one register stage. Depends on mat_pkg.
`default_nettype none

module mat_core #(
    parameter int TURN_FOLD_LIMIT = mat_pkg::TURN_FOLD_LIMIT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire mat_pkg::t_sample i_data,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output mat_pkg::t_result     o_data
);
    import mat_pkg::*;

    localparam int SUM_W = ANGLE_W + 2;
    localparam logic signed [TC_W-1:0] FOLD_LIM = TC_W'(TURN_FOLD_LIMIT);
    localparam logic signed [SUM_W-1:0] MAX48 = SUM_W'({1'b0, {(ANGLE_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] MIN48 = -MAX48 - SUM_W'(1);
    localparam logic signed [TURN_W:0] HALF_S = (TURN_W+1)'(HALF_TURN_Q);

    logic                       r_init;
    logic                       r_pend;
    logic signed [ANGLE_W-1:0]  r_pend_tgt;
    logic [TURN_W-1:0]          r_start;
    logic [TURN_W-1:0]          r_prev;
    logic signed [TC_W-1:0]     r_tc;
    logic signed [ANGLE_W-1:0]  r_fine;

    logic                       n_init;
    logic                       n_pend;
    logic signed [ANGLE_W-1:0]  n_pend_tgt;
    logic [TURN_W-1:0]          n_start;
    logic [TURN_W-1:0]          n_prev;
    logic signed [TC_W-1:0]     n_tc;
    logic signed [ANGLE_W-1:0]  n_fine;
    logic signed [ANGLE_W-1:0]  n_total;

    logic                       take;
    logic signed [TURN_W:0]     delta;
    logic signed [TC_W-1:0]     tc_step;
    logic signed [SUM_W-1:0]    tq_old;
    logic signed [SUM_W-1:0]    tq_new;
    logic signed [SUM_W-1:0]    cur_x;
    logic signed [SUM_W-1:0]    start_x;
    logic signed [SUM_W-1:0]    prev_x;
    logic signed [SUM_W-1:0]    fine_x;
    logic signed [SUM_W-1:0]    sum_total;
    logic signed [SUM_W-1:0]    sum_fold;
    logic signed [SUM_W-1:0]    sum_reloc;
    logic                       fold;

    // Turns to Q16.16 degrees: tc * 45 * 2^19
    function automatic logic signed [SUM_W-1:0] turns_q(input logic signed [TC_W-1:0] tc);
        logic signed [SUM_W-1:0] t;
        t = SUM_W'(tc);
        return ((t <<< 5) + (t <<< 3) + (t <<< 2) + t) <<< FRAC_SH;
    endfunction

    function automatic logic signed [ANGLE_W-1:0] sat48(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] c;
        c = v;
        if (v > MAX48) begin
            c = MAX48;
        end else if (v < MIN48) begin
            c = MIN48;
        end
        return ANGLE_W'(c);
    endfunction

    assign o_ready = !o_valid || i_ready;
    assign take    = i_valid && o_ready;

    always_comb begin
        delta = $signed({1'b0, i_data.cur}) - $signed({1'b0, r_prev});
        tc_step = r_tc;
        priority if (delta > HALF_S) begin
            tc_step = r_tc - TC_W'(1);
        end else if (delta < -HALF_S) begin
            tc_step = r_tc + TC_W'(1);
        end

        tq_old  = turns_q(r_tc);
        tq_new  = turns_q(tc_step);
        cur_x   = $signed(SUM_W'(i_data.cur));
        start_x = $signed(SUM_W'(r_start));
        prev_x  = $signed(SUM_W'(r_prev));
        fine_x  = SUM_W'(r_fine);

        sum_total = tq_new + cur_x - start_x + fine_x;
        sum_fold  = fine_x + tq_new;
        sum_reloc = SUM_W'(i_data.target) - (tq_old + prev_x - start_x);
        fold      = (tc_step > FOLD_LIM) || (tc_step < -FOLD_LIM);

        n_init     = r_init;
        n_pend     = r_pend;
        n_pend_tgt = r_pend_tgt;
        n_start    = r_start;
        n_prev     = r_prev;
        n_tc       = r_tc;
        n_fine     = r_fine;
        n_total    = i_data.target;

        if (i_data.req == REQ_RELOCATE) begin
            // Before the first sample, hold the target until initialisation
            if (!r_init) begin
                n_pend     = 1'b1;
                n_pend_tgt = i_data.target;
            end else begin
                n_fine = sat48(sum_reloc);
            end
        end else if (!r_init) begin
            // First sample sets the zero reference
            n_init  = 1'b1;
            n_start = i_data.cur;
            n_prev  = i_data.cur;
            n_tc    = '0;
            n_fine  = r_pend ? r_pend_tgt : '0;
            n_total = n_fine;
            n_pend  = 1'b0;
        end else begin
            n_prev  = i_data.cur;
            n_total = sat48(sum_total);
            if (fold) begin
                n_fine = sat48(sum_fold);
                n_tc   = '0;
            end else begin
                n_tc = tc_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid    <= 1'b0;
            r_init     <= 1'b0;
            r_pend     <= 1'b0;
            r_pend_tgt <= '0;
            r_start    <= '0;
            r_prev     <= '0;
            r_tc       <= '0;
            r_fine     <= '0;
        end else begin
            if (o_ready) begin
                o_valid <= i_valid;
            end
            if (take) begin
                r_init     <= n_init;
                r_pend     <= n_pend;
                r_pend_tgt <= n_pend_tgt;
                r_start    <= n_start;
                r_prev     <= n_prev;
                r_tc       <= n_tc;
                r_fine     <= n_fine;
            end
        end
        if (take) begin
            o_data.total <= n_total;
            o_data.init  <= n_init;
        end
    end

endmodule

`default_nettype wire

FILE: design/mat_wrap.sv
// Output stage of the multi-turn angle tracker: wraps the total into one turn
// and holds the result beat for the receiver. Depends on mat_pkg.
`default_nettype none

module mat_wrap (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire mat_pkg::t_result                   i_data,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output logic signed [mat_pkg::ANGLE_W-1:0]      o_total,
    output logic [mat_pkg::TURN_W-1:0]              o_wrapped,
    output logic                                    o_init
);
    import mat_pkg::*;

    logic signed [WR_H_W-1:0]       h;
    logic [WR_U_W-1:0]              hu;
    logic [WR_U_W+WR_REC_W-1:0]     h_mul;
    logic [WR_U_W-1:0]              h_div;
    logic [5:0]                     h_rem;

    assign o_ready = !o_valid || i_ready;

    // Floor modulo: lift the turn part by a multiple of 45, then reduce
    assign h     = i_data.total[ANGLE_W-1:FRAC_SH];
    assign hu    = WR_U_W'(h) + WR_BIAS;
    assign h_mul = (WR_U_W+WR_REC_W)'(hu) * (WR_U_W+WR_REC_W)'(WR_REC);
    assign h_div = WR_U_W'(h_mul >> WR_REC_SH);
    assign h_rem = rem45(hu, h_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (o_ready) begin
            o_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            o_total   <= i_data.total;
            o_wrapped <= {h_rem, i_data.total[FRAC_SH-1:0]};
            o_init    <= i_data.init;
        end
    end

endmodule

`default_nettype wire

FILE: design/multiturn_angle_tracker.sv
// Multi-turn angle tracker, top level: configuration register and the
// four-stage pipeline. Depends on mat_pkg, mat_scale, mat_core and mat_wrap.
//
// Usage
//   Input channel (i_in_valid / o_in_ready) carries one beat per request:
//   an encoder sample (i_req_type 0, i_raw_value) or a relocate
//   (i_req_type 1, i_target_angle). Each beat yields exactly one result beat
//   on the output channel (o_out_valid / i_out_ready): the total angle in
//   Q16.16 degrees saturated to 48 bits, the total wrapped into 0..360
//   degrees, and whether the first sample has been taken.
//   One beat per cycle is sustained while the receiver does not stall.
//   Stage one multiplies by the scale, stage two reduces it modulo one
//   turn, stage three updates the tracking state, stage four wraps.
//   Each stage advances whenever its successor is empty or moving, so
//   bubbles are squeezed out and new beats are taken while a result waits.
//   When the receiver stalls, the result is held and the pipe fills; once
//   full, o_in_ready drops.
//   i_cfg_we writes degrees-per-count; write it only while idle.
//   Synchronous reset empties the pipe, clears all tracking state and loads
//   the default scale of 2880 (a 13-bit encoder).
`default_nettype none

module multiturn_angle_tracker #(
    parameter int TURN_FOLD_LIMIT = mat_pkg::TURN_FOLD_LIMIT_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [mat_pkg::DPC_W-1:0]            i_cfg_wdata,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_req_type,
    input  wire logic [mat_pkg::RAW_W-1:0]            i_raw_value,
    input  wire logic signed [mat_pkg::ANGLE_W-1:0]   i_target_angle,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [mat_pkg::ANGLE_W-1:0]        o_total_angle,
    output logic [mat_pkg::TURN_W-1:0]                o_wrapped_angle,
    output logic                                      o_initialised
);
    import mat_pkg::*;

    logic [DPC_W-1:0] r_deg_per_count;

    logic    sc_valid;
    logic    sc_ready;
    t_sample sc_data;
    logic    co_valid;
    logic    co_ready;
    t_result co_data;

    // Scale register: plain write, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_per_count <= DPC_RESET;
        end else if (i_cfg_we) begin
            r_deg_per_count <= i_cfg_wdata;
        end
    end

    mat_scale u_scale (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_dpc    (r_deg_per_count),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_req    (i_req_type),
        .i_raw    (i_raw_value),
        .i_target (i_target_angle),
        .o_valid  (sc_valid),
        .i_ready  (sc_ready),
        .o_data   (sc_data)
    );

    mat_core #(
        .TURN_FOLD_LIMIT (TURN_FOLD_LIMIT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sc_valid),
        .o_ready (sc_ready),
        .i_data  (sc_data),
        .o_valid (co_valid),
        .i_ready (co_ready),
        .o_data  (co_data)
    );

    mat_wrap u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (co_valid),
        .o_ready   (co_ready),
        .i_data    (co_data),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_total   (o_total_angle),
        .o_wrapped (o_wrapped_angle),
        .o_init    (o_initialised)
    );

    // Wrapped angle stays inside one turn
    a_wrap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wrapped_angle < TURN_Q))
        else $error("wrapped angle outside one turn");

    // Wrapping only changes whole multiples of 2^19
    a_wrap_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_wrapped_angle[FRAC_SH-1:0] == o_total_angle[FRAC_SH-1:0]))
        else $error("wrapped angle fraction differs from total");

    // Scaled reading handed to the core is already reduced to one turn
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sc_valid |-> (sc_data.cur < TURN_Q))
        else $error("scaled reading outside one turn");

endmodule

`default_nettype wire

FILE: bench/angle_tracker_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the multi-turn angle tracker: watches the register port and both channels,
// predicts every result beat and compares it field by field. Depends on mat_pkg.
module angle_tracker_checker #(
    parameter int FOLD_LIMIT = mat_pkg::TURN_FOLD_LIMIT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mat_pkg::DPC_W-1:0]             i_cfg_wdata,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_req_type,
    input  logic [mat_pkg::RAW_W-1:0]             i_raw_value,
    input  logic signed [mat_pkg::ANGLE_W-1:0]    i_target_angle,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic signed [mat_pkg::ANGLE_W-1:0]    i_total_angle,
    input  logic [mat_pkg::TURN_W-1:0]            i_wrapped_angle,
    input  logic                                  i_initialised,
    output int                                    o_errors,
    output int                                    o_outstanding
);
    import mat_pkg::*;

    localparam longint TURN_LEN = longint'(TURN_Q);
    localparam longint HALF_LEN = longint'(HALF_TURN_Q);
    localparam longint SAT_HI   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SAT_LO   = -SAT_HI - 64'sd1;

    typedef struct packed {
        logic signed [ANGLE_W-1:0] total;
        logic [TURN_W-1:0]         wrapped;
        logic                      init;
    } t_angle_beat;

    t_angle_beat expected_angles [$];

    // Shadow of the tracking state
    logic [DPC_W-1:0] scale;
    logic             have_ref;
    logic             hold_flag;
    longint           hold_target;
    longint           zero_ref;
    longint           prev_angle;
    longint           offset;
    int               turns;
    int               error_count;

    function automatic longint clamp48(input longint v);
        if (v > SAT_HI) return SAT_HI;
        if (v < SAT_LO) return SAT_LO;
        return v;
    endfunction

    function automatic longint wrap_turn(input longint v);
        longint r;
        r = v % TURN_LEN;
        if (r < 0) r += TURN_LEN;
        return r;
    endfunction

    task automatic track_angle(input logic req, input logic [RAW_W-1:0] raw,
                               input logic signed [ANGLE_W-1:0] tgt,
                               output t_angle_beat res);
        longint cur;
        longint calc;
        longint total;
        longint delta;
        if (req == REQ_RELOCATE) begin
            if (!have_ref) begin
                hold_flag   = 1'b1;
                hold_target = longint'(tgt);
            end else begin
                calc   = longint'(turns) * TURN_LEN + prev_angle - zero_ref;
                offset = clamp48(longint'(tgt) - calc);
            end
            total = longint'(tgt);
        end else begin
            cur = (longint'(raw) * longint'(scale)) % TURN_LEN;
            if (!have_ref) begin
                zero_ref   = cur;
                prev_angle = cur;
                turns      = 0;
                offset     = hold_flag ? hold_target : 0;
                total      = offset;
                hold_flag  = 1'b0;
                have_ref   = 1'b1;
            end else begin
                delta = cur - prev_angle;
                if (delta > HALF_LEN)       turns--;
                else if (delta < -HALF_LEN) turns++;
                prev_angle = cur;
                total = clamp48(longint'(turns) * TURN_LEN + cur - zero_ref + offset);
                // fold excess turns into the offset
                if (turns > FOLD_LIMIT || turns < -FOLD_LIMIT) begin
                    offset = clamp48(offset + longint'(turns) * TURN_LEN);
                    turns  = 0;
                end
            end
        end
        res.total   = total[ANGLE_W-1:0];
        res.wrapped = TURN_W'(wrap_turn(total));
        res.init    = have_ref;
    endtask

    always @(posedge i_clk) begin : watch
        t_angle_beat want;
        t_angle_beat seen;
        if (!i_rst_n) begin
            scale       = DPC_RESET;
            have_ref    = 1'b0;
            hold_flag   = 1'b0;
            hold_target = 0;
            zero_ref    = 0;
            prev_angle  = 0;
            offset      = 0;
            turns       = 0;
            error_count = 0;
            expected_angles.delete();
        end else begin
            if (i_cfg_we) scale = i_cfg_wdata;
            if (i_out_valid && i_out_ready) begin
                seen.total   = i_total_angle;
                seen.wrapped = i_wrapped_angle;
                seen.init    = i_initialised;
                if (expected_angles.size() == 0) begin
                    $display("%0t: result beat with nothing expected, total %0d",
                             $time, $signed(seen.total));
                    error_count++;
                end else begin
                    want = expected_angles.pop_front();
                    if (seen.total !== want.total) begin
                        $display("%0t: total_angle expected %0d actual %0d",
                                 $time, $signed(want.total), $signed(seen.total));
                        error_count++;
                    end
                    if (seen.wrapped !== want.wrapped) begin
                        $display("%0t: wrapped_angle expected %0d actual %0d",
                                 $time, want.wrapped, seen.wrapped);
                        error_count++;
                    end
                    if (seen.init !== want.init) begin
                        $display("%0t: initialised expected %0d actual %0d",
                                 $time, want.init, seen.init);
                        error_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                track_angle(i_req_type, i_raw_value, i_target_angle, want);
                expected_angles.push_back(want);
            end
        end
        o_outstanding <= expected_angles.size();
        o_errors      <= error_count;
    end

endmodule

FILE: bench/tb_multiturn_angle_tracker.sv
`timescale 1ns / 1ps
// Top of the angle tracker bench: clock, reset, stimulus and the verdict.
// Depends on mat_pkg, multiturn_angle_tracker and angle_tracker_checker.
module tb_multiturn_angle_tracker;
    import mat_pkg::*;

    // A small fold limit lets the random runs fold turns many times per phase
    localparam int FOLD_LIMIT      = 24;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int SCALE_PHASES    = 9;
    // The pipe has four stages; leave idle time after it drains, before touching the register
    localparam int DRAIN_CYCLES    = 8;
    // About 2000 beats; even at the receiver's worst choke plus sender gaps
    // this stays well under a tenth of the limit
    localparam int CYCLE_LIMIT     = 1_000_000;

    localparam longint TURN_LEN = longint'(TURN_Q);
    localparam logic signed [ANGLE_W-1:0] ANG_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [ANGLE_W-1:0] ANG_MIN = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CHOKE} t_rx_mode;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_cfg_we       = 1'b0;
    logic [DPC_W-1:0]          i_cfg_wdata    = '0;
    logic                      i_in_valid     = 1'b0;
    logic                      i_req_type     = REQ_SAMPLE;
    logic [RAW_W-1:0]          i_raw_value    = '0;
    logic signed [ANGLE_W-1:0] i_target_angle = '0;
    logic                      i_out_ready    = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic signed [ANGLE_W-1:0] o_total_angle;
    logic [TURN_W-1:0]         o_wrapped_angle;
    logic                      o_initialised;

    int tracker_errors;
    int tracker_outstanding;

    int               cycle_count = 0;
    int               burst_left  = 0;
    int               beats_sent  = 0;
    logic [DPC_W-1:0] cur_scale   = DPC_RESET;
    logic [RAW_W-1:0] raw_pos     = '0;
    logic [DPC_W-1:0] scale_plan [0:SCALE_PHASES-1];
    t_rx_mode         rx_mode     = RX_OPEN;
    int               mode_left   = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    multiturn_angle_tracker #(
        .TURN_FOLD_LIMIT (FOLD_LIMIT)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_raw_value     (i_raw_value),
        .i_target_angle  (i_target_angle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_total_angle   (o_total_angle),
        .o_wrapped_angle (o_wrapped_angle),
        .o_initialised   (o_initialised)
    );

    angle_tracker_checker #(
        .FOLD_LIMIT (FOLD_LIMIT)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_raw_value     (i_raw_value),
        .i_target_angle  (i_target_angle),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_total_angle   (o_total_angle),
        .i_wrapped_angle (o_wrapped_angle),
        .i_initialised   (o_initialised),
        .o_errors        (tracker_errors),
        .o_outstanding   (tracker_outstanding)
    );

    // Watchdog: end the run if it hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_multiturn_angle_tracker: errors");
            $finish;
        end
    end

    // Receiver: switch at random between back-pressure patterns,
    // from always ready to a near-choke with long stalls
    always @(posedge i_clk) begin
        if (mode_left == 0) begin
            rx_mode   <= t_rx_mode'($urandom_range(0, 3));
            mode_left <= $urandom_range(16, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   i_out_ready <= 1'b1;
            RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: i_out_ready <= ($urandom_range(0, 3) == 0);
            default:   i_out_ready <= ($urandom_range(0, 29) == 0);
        endcase
    end

    // Offer one beat and hold it until taken. Between bursts, drop valid for
    // a random gap; some bursts are long so stretches without idling occur.
    task automatic send_beat(input logic req, input logic [RAW_W-1:0] raw,
                             input logic signed [ANGLE_W-1:0] tgt);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= req;
        i_raw_value    <= raw;
        i_target_angle <= tgt;
        do @(posedge i_clk); while (!o_in_ready);
        burst_left--;
        beats_sent++;
    endtask

    // Hold off the sender until every expected result has arrived, then let
    // the pipe settle before going on
    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (tracker_outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [ANGLE_W-1:0] random_angle();
        return ANGLE_W'({$urandom(), $urandom()});
    endfunction

    initial begin : stimulus
        int     phase;
        int     phase_start;
        int     k;
        int     run_len;
        int     pick;
        int     pct;
        bit     fast;
        bit     fwd;
        longint per_turn;
        longint step;
        logic signed [ANGLE_W-1:0] tgt;

        // Register settings: unit scale, a full turn per count (every sample
        // reads zero), zero scale, half a turn per count (jumps of exactly
        // 180 degrees), 16-bit and 12-bit encoders, the top bit set, a random
        // one, and back to the default
        scale_plan[0] = 25'd1;
        scale_plan[1] = DPC_W'(TURN_Q);
        scale_plan[2] = 25'd0;
        scale_plan[3] = DPC_W'(HALF_TURN_Q);
        scale_plan[4] = 25'd360;
        scale_plan[5] = 25'd16777216;
        scale_plan[6] = DPC_W'($urandom_range(1, 23592960));
        scale_plan[7] = 25'd5760;
        scale_plan[8] = DPC_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, default scale of 2880 (8192 counts a turn).
        // Relocates before the first sample: held, the second overwrites the first.
        send_beat(REQ_RELOCATE, 16'hFFFF, 48'sd1000);
        send_beat(REQ_RELOCATE, 16'h0000, 48'sd123456789);
        // First sample picks up the held target; junk in the unused field
        send_beat(REQ_SAMPLE, 16'd100, 48'shFFFF_FFFF_FFFF);
        // Full-scale reading runs past one turn and wraps
        send_beat(REQ_SAMPLE, 16'hFFFF, ANG_MIN);
        send_beat(REQ_SAMPLE, 16'd0, ANG_MAX);
        // Jumps of exactly half a turn count nothing, one count more does
        send_beat(REQ_SAMPLE, 16'd4096, '0);
        send_beat(REQ_SAMPLE, 16'd0, '0);
        send_beat(REQ_SAMPLE, 16'd4097, '0);
        send_beat(REQ_SAMPLE, 16'd1, '0);
        // Relocate to the top: offset saturates, then totals saturate high
        send_beat(REQ_RELOCATE, 16'd0, ANG_MAX);
        send_beat(REQ_SAMPLE, 16'd2000, '0);
        send_beat(REQ_SAMPLE, 16'd7000, '0);
        send_beat(REQ_SAMPLE, 16'd3000, '0);
        // Relocate to the bottom, then turn down to push totals low
        send_beat(REQ_RELOCATE, 16'hFFFF, ANG_MIN);
        send_beat(REQ_SAMPLE, 16'd10, '0);
        send_beat(REQ_SAMPLE, 16'd4300, '0);
        send_beat(REQ_SAMPLE, 16'd200, '0);
        send_beat(REQ_RELOCATE, 16'd0, 48'sd0);
        send_beat(REQ_SAMPLE, 16'd32768, random_angle());
        send_beat(REQ_SAMPLE, 16'd65535, random_angle());

        for (phase = 0; phase < SCALE_PHASES; phase++) begin
            drain_pipe();
            i_cfg_we    <= 1'b1;
            i_cfg_wdata <= scale_plan[phase];
            cur_scale    = scale_plan[phase];
            @(posedge i_clk);
            i_cfg_we    <= 1'b0;

            per_turn    = (cur_scale == 0) ? 8192 : TURN_LEN / longint'(cur_scale);
            phase_start = beats_sent;
            while (beats_sent - phase_start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    // Rotation run: slow tracking or fast steps past half a turn
                    // that keep counting turns in one direction and force folds
                    run_len = $urandom_range(4, 40);
                    fast    = ($urandom_range(0, 2) == 0);
                    fwd     = 1'($urandom_range(0, 1));
                    for (k = 0; k < run_len; k++) begin
                        pct  = fast ? $urandom_range(52, 95) : $urandom_range(0, 12);
                        step = per_turn * pct / 100;
                        if (step > 65535) step = 65535;
                        raw_pos = fwd ? raw_pos + RAW_W'(step) : raw_pos - RAW_W'(step);
                        send_beat(REQ_SAMPLE, raw_pos, random_angle());
                    end
                end else if (pick < 85) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: tgt = ANGLE_W'(longint'($urandom_range(0, 200000000))
                                                      - 64'sd100000000);
                        5, 6, 7:       tgt = random_angle();
                        8:             tgt = ($urandom_range(0, 1) != 0) ? ANG_MAX : ANG_MIN;
                        default:       tgt = ($urandom_range(0, 1) != 0)
                                             ? ANG_MAX - ANGLE_W'($urandom_range(0, 99999999))
                                             : ANG_MIN + ANGLE_W'($urandom_range(0, 99999999));
                    endcase
                    send_beat(REQ_RELOCATE, RAW_W'($urandom()), tgt);
                end else if (pick < 97) begin
                    // Noise: a reading from anywhere
                    raw_pos = RAW_W'($urandom());
                    send_beat(REQ_SAMPLE, raw_pos, random_angle());
                end else begin
                    drain_pipe();
                end
            end
        end

        drain_pipe();
        if (tracker_errors == 0) begin
            $display("tb_multiturn_angle_tracker: clean");
        end else begin
            $display("tb_multiturn_angle_tracker: errors");
        end
        $finish;
    end

endmodule
